@@ sv/rfcfb_pkg.sv @@
// ----------------------------------------------------------------------------
// rfcfb_pkg
// Shared constants, types and functions of the command frame builder.
// ----------------------------------------------------------------------------
package rfcfb_pkg;

  localparam int unsigned ADDR_WIDTH = 16;
  localparam int unsigned TOG_DEPTH  = 1 << ADDR_WIDTH;

  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [7:0] FMT_DEFAULT = 8'hFF;
  localparam logic [7:0] FMT_NONE    = 8'd0;
  localparam logic [7:0] FMT_LEVEL   = 8'd1;
  localparam logic [7:0] FMT_RGB     = 8'd3;

  localparam logic [7:0] CMD_PLAIN_LAST = 8'd5;
  localparam logic [7:0] CMD_SET        = 8'd6;
  localparam logic [7:0] CMD_PLAIN_9    = 8'd9;
  localparam logic [7:0] CMD_PLAIN_10   = 8'd10;
  localparam logic [7:0] CMD_PLAIN_15   = 8'd15;
  localparam logic [7:0] CMD_PLAIN_17   = 8'd17;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_FMT = 2'd1;
  localparam logic [1:0] STAT_UNSUP   = 2'd2;

  typedef struct packed {
    logic [7:0]  command_code;
    logic [7:0]  format_code;
    logic [7:0]  level;
    logic        color_given;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        toggle_given;
    logic        toggle_value;
    logic [15:0] address;
  } cmd_t;

  // Frame bytes before the CRC, the number of those bytes and the error code.
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [3:0]      len;
    logic            err;
    logic [1:0]      status;
  } frame_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_WIDTH-1:0] addr;
    logic                  data;
  } tog_wr_t;

  function automatic logic is_plain(input logic [7:0] cmd);
    return (cmd <= CMD_PLAIN_LAST) || (cmd == CMD_PLAIN_9) || (cmd == CMD_PLAIN_10) ||
           (cmd == CMD_PLAIN_15) || (cmd == CMD_PLAIN_17);
  endfunction

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

@@ sv/rfcfb_if.sv @@
// ----------------------------------------------------------------------------
// rfcfb_if
// Valid/ready channels for commands and frame bytes.
// ----------------------------------------------------------------------------
interface rfcfb_cmd_if;
  logic        valid;
  logic        ready;
  logic [7:0]  command_code;
  logic [7:0]  format_code;
  logic [7:0]  level;
  logic        color_given;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        toggle_given;
  logic        toggle_value;
  logic [15:0] address;

  modport source (output valid, command_code, format_code, level, color_given, red, green,
                  blue, toggle_given, toggle_value, address, input ready);
  modport sink (input valid, command_code, format_code, level, color_given, red, green,
                blue, toggle_given, toggle_value, address, output ready);
endinterface

interface rfcfb_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  logic [1:0] status;

  modport source (output valid, frame_byte, last_byte, status, input ready);
  modport sink (input valid, frame_byte, last_byte, status, output ready);
endinterface

@@ sv/rfcfb_toggle_mem.sv @@
// ----------------------------------------------------------------------------
// rfcfb_toggle_mem
// Per-address toggle bit store with a clearing pass after reset and
// forwarding of the most recent write.
// ----------------------------------------------------------------------------
module rfcfb_toggle_mem (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rd_en_i,
  input  logic [rfcfb_pkg::ADDR_WIDTH-1:0]   rd_addr_i,
  input  rfcfb_pkg::tog_wr_t                 tog_wr_i,
  output logic                               rd_data_o,
  output logic                               clear_busy_o
);
  import rfcfb_pkg::*;

  logic                  mem_q [TOG_DEPTH];
  logic                  rd_data_q;
  logic [ADDR_WIDTH-1:0] rd_addr_q;
  logic [ADDR_WIDTH:0]   clr_cnt_q, clr_cnt_d;
  logic                  lw_valid_q, lw_valid_d;
  logic [ADDR_WIDTH-1:0] lw_addr_q;
  logic                  lw_data_q;
  logic                  mem_we;
  logic [ADDR_WIDTH-1:0] mem_waddr;
  logic                  mem_wdata;

  assign clear_busy_o = !clr_cnt_q[ADDR_WIDTH];
  assign clr_cnt_d    = clear_busy_o ? clr_cnt_q + 1'b1 : clr_cnt_q;
  assign lw_valid_d   = lw_valid_q || tog_wr_i.en;

  assign mem_we    = clear_busy_o || tog_wr_i.en;
  assign mem_waddr = clear_busy_o ? clr_cnt_q[ADDR_WIDTH-1:0] : tog_wr_i.addr;
  assign mem_wdata = clear_busy_o ? 1'b0 : tog_wr_i.data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
    if (tog_wr_i.en) begin
      lw_addr_q <= tog_wr_i.addr;
      lw_data_q <= tog_wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      lw_valid_q <= 1'b0;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      lw_valid_q <= lw_valid_d;
    end
  end

  // The latest write to the entry being read wins over the array output.
  assign rd_data_o = (lw_valid_q && (lw_addr_q == rd_addr_q)) ? lw_data_q : rd_data_q;

endmodule

@@ sv/rfcfb_frame_build.sv @@
// ----------------------------------------------------------------------------
// rfcfb_frame_build
// Resolves the toggle bit, writes it back and assembles the frame bytes.
// ----------------------------------------------------------------------------
module rfcfb_frame_build (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  rfcfb_pkg::cmd_t     cmd_i,
  input  logic                tog_rd_i,
  input  logic                take_i,
  output logic                s1_busy_o,
  output logic                s2_valid_o,
  output rfcfb_pkg::frame_t   frame_o,
  output rfcfb_pkg::tog_wr_t  tog_wr_o
);
  import rfcfb_pkg::*;

  logic   s1_valid_q, s1_valid_d;
  cmd_t   item_q;
  logic   s2_valid_q, s2_valid_d;
  frame_t frame_q;
  frame_t built;
  logic   tog;
  logic   [7:0] fmt_eff;
  logic   [7:0] lo;
  logic   [7:0] hi;

  assign tog = item_q.toggle_given ? item_q.toggle_value : !tog_rd_i;

  assign tog_wr_o.en   = s1_valid_q;
  assign tog_wr_o.addr = item_q.address[ADDR_WIDTH-1:0];
  assign tog_wr_o.data = tog;

  assign lo = item_q.address[7:0];
  assign hi = item_q.address[15:8];

  always_comb begin
    built          = '0;
    built.bytes[0] = {item_q.command_code[3:0], tog, 3'b000};
    built.status   = STAT_OK;
    fmt_eff        = item_q.format_code;
    if (is_plain(item_q.command_code)) begin
      if (item_q.format_code == FMT_DEFAULT) begin
        fmt_eff = FMT_NONE;
      end
      if ((fmt_eff != FMT_NONE)) begin
        built.err    = 1'b1;
        built.status = STAT_BAD_FMT;
      end else begin
        built.bytes[1] = lo;
        built.bytes[2] = hi;
        built.bytes[3] = fmt_eff;
        built.len      = 4'd4;
      end
    end else if (item_q.command_code == CMD_SET) begin
      if (item_q.format_code == FMT_DEFAULT) begin
        fmt_eff = item_q.color_given ? FMT_RGB : FMT_LEVEL;
      end
      if (fmt_eff == FMT_LEVEL) begin
        built.bytes[1] = item_q.level;
        built.bytes[2] = lo;
        built.bytes[3] = hi;
        built.bytes[4] = fmt_eff;
        built.len      = 4'd5;
      end else if (fmt_eff == FMT_RGB) begin
        built.bytes[1] = item_q.red;
        built.bytes[2] = item_q.green;
        built.bytes[3] = item_q.blue;
        built.bytes[4] = 8'd0;
        built.bytes[5] = lo;
        built.bytes[6] = hi;
        built.bytes[7] = fmt_eff;
        built.len      = 4'd8;
      end else begin
        built.err    = 1'b1;
        built.status = STAT_BAD_FMT;
      end
    end else begin
      built.err    = 1'b1;
      built.status = STAT_UNSUP;
    end
  end

  assign s1_valid_d = accept_i;
  assign s2_valid_d = s1_valid_q || (s2_valid_q && !take_i);

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= cmd_i;
    end
    if (s1_valid_q) begin
      frame_q <= built;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  assign s1_busy_o  = s1_valid_q;
  assign s2_valid_o = s2_valid_q;
  assign frame_o    = frame_q;

endmodule

@@ sv/rfcfb_serializer.sv @@
// ----------------------------------------------------------------------------
// rfcfb_serializer
// Sends the frame one byte per transaction and appends the running CRC-8.
// ----------------------------------------------------------------------------
module rfcfb_serializer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s2_valid_i,
  input  rfcfb_pkg::frame_t  frame_i,
  output logic               take_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output logic [1:0]         out_status_o
);
  import rfcfb_pkg::*;

  logic       busy_q, busy_d;
  frame_t     frame_q;
  logic [3:0] k_q, k_d;
  logic [7:0] crc_q, crc_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic [1:0] out_status_q, out_status_d;
  logic       out_adv;
  logic       emit;
  logic       done_now;
  logic [7:0] cur_byte;

  assign out_adv  = !out_valid_q || out_ready_i;
  assign emit     = busy_q && out_adv;
  assign done_now = emit && (frame_q.err || (k_q == frame_q.len));
  assign take_o   = s2_valid_i && (!busy_q || done_now);
  assign cur_byte = frame_q.bytes[k_q[2:0]];

  always_comb begin
    busy_d       = busy_q;
    k_d          = k_q;
    crc_d        = crc_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    if (out_adv) begin
      out_valid_d = emit;
    end
    if (emit) begin
      if (frame_q.err) begin
        out_byte_d   = 8'd0;
        out_last_d   = 1'b1;
        out_status_d = frame_q.status;
      end else if (k_q < frame_q.len) begin
        out_byte_d   = cur_byte;
        out_last_d   = 1'b0;
        out_status_d = STAT_OK;
        crc_d        = crc8_byte(crc_q, cur_byte);
        k_d          = k_q + 4'd1;
      end else begin
        out_byte_d   = crc_q;
        out_last_d   = 1'b1;
        out_status_d = STAT_OK;
      end
    end
    if (done_now) begin
      busy_d = 1'b0;
    end
    if (take_o) begin
      busy_d = 1'b1;
      k_d    = '0;
      crc_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      frame_q <= frame_i;
    end
    k_q          <= k_d;
    crc_q        <= crc_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

endmodule

@@ sv/rf_command_frame_builder_core.sv @@
// ----------------------------------------------------------------------------
// rf_command_frame_builder_core
// Builds the byte frame of one remote-control command with a CRC-8 trailer.
// ----------------------------------------------------------------------------
// After reset the block clears its toggle memory, one entry per cycle, and
// accepts no command until the clearing pass is done. Each command then
// yields 5, 6 or 9 frame bytes, or one error result, one byte per cycle
// while the output is ready. The command is registered, then its built
// frame, then each output byte in the serializer. The byte serializer sets
// the sustained rate and loads the next frame as it sends the last byte of
// the previous one. A new command is taken while a frame is still being sent.
module rf_command_frame_builder_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  rfcfb_cmd_if.sink     cmd_i,
  rfcfb_frame_if.source frame_o
);
  import rfcfb_pkg::*;

  cmd_t    cmd;
  frame_t  frame;
  tog_wr_t tog_wr;
  logic    accept;
  logic    clear_busy;
  logic    s1_busy;
  logic    s2_valid;
  logic    take;
  logic    tog_rd;

  assign cmd.command_code = cmd_i.command_code;
  assign cmd.format_code  = cmd_i.format_code;
  assign cmd.level        = cmd_i.level;
  assign cmd.color_given  = cmd_i.color_given;
  assign cmd.red          = cmd_i.red;
  assign cmd.green        = cmd_i.green;
  assign cmd.blue         = cmd_i.blue;
  assign cmd.toggle_given = cmd_i.toggle_given;
  assign cmd.toggle_value = cmd_i.toggle_value;
  assign cmd.address      = cmd_i.address;

  assign cmd_i.ready = !clear_busy && !s1_busy && (!s2_valid || take);
  assign accept      = cmd_i.valid && cmd_i.ready;

  rfcfb_toggle_mem u_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (accept),
    .rd_addr_i    (cmd_i.address[ADDR_WIDTH-1:0]),
    .tog_wr_i     (tog_wr),
    .rd_data_o    (tog_rd),
    .clear_busy_o (clear_busy)
  );

  rfcfb_frame_build u_build (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (cmd),
    .tog_rd_i   (tog_rd),
    .take_i     (take),
    .s1_busy_o  (s1_busy),
    .s2_valid_o (s2_valid),
    .frame_o    (frame),
    .tog_wr_o   (tog_wr)
  );

  rfcfb_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s2_valid_i   (s2_valid),
    .frame_i      (frame),
    .take_o       (take),
    .out_ready_i  (frame_o.ready),
    .out_valid_o  (frame_o.valid),
    .out_byte_o   (frame_o.frame_byte),
    .out_last_o   (frame_o.last_byte),
    .out_status_o (frame_o.status)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> tog_wr.en)
    else $error("Accepted command did not write back its toggle bit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_busy |-> !s2_valid)
    else $error("Frame handoff buffer would be overwritten.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !s1_busy && !s2_valid && !frame_o.valid)
    else $error("Command in flight during the toggle memory clearing pass.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_o.valid && (frame_o.status != STAT_OK)) |-> frame_o.last_byte)
    else $error("Error result not marked as last byte.");
`endif

endmodule

@@ dv/rfcfb_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// rfcfb_tb_pkg
// Frame scoreboard for the command frame builder testbench. It keeps its own
// per-address toggle memory, builds the expected frame bytes of each accepted
// command and compares them in order with the bytes that leave the block.
// ----------------------------------------------------------------------------
package rfcfb_tb_pkg;

  import rfcfb_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [1:0] status;
  } frame_beat_t;

  class frame_scoreboard;

    bit          toggle_bits [TOG_DEPTH];
    frame_beat_t expected_beats [$];
    int unsigned failures;

    function void flag_failure(string msg);
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("ERROR: %s", msg);
      end
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    function void push_error(logic [1:0] code);
      frame_beat_t beat;
      beat.frame_byte = 8'h00;
      beat.last_byte  = 1'b1;
      beat.status     = code;
      expected_beats.push_back(beat);
    endfunction

    function void note_command(cmd_t c);
      logic [7:0]  frame [$];
      logic [7:0]  fmt;
      logic [7:0]  crc;
      logic [7:0]  data;
      logic        tog;
      logic        mix;
      int unsigned slot;
      frame_beat_t beat;
      slot = c.address[ADDR_WIDTH-1:0];
      tog = c.toggle_given ? c.toggle_value : !toggle_bits[slot];
      toggle_bits[slot] = tog;
      frame.push_back({c.command_code[3:0], tog, 3'b000});
      fmt = c.format_code;
      if ((c.command_code <= CMD_PLAIN_LAST) ||
          (c.command_code inside {CMD_PLAIN_9, CMD_PLAIN_10, CMD_PLAIN_15, CMD_PLAIN_17})) begin
        if (fmt == FMT_DEFAULT) begin
          fmt = FMT_NONE;
        end else if (fmt != FMT_NONE) begin
          push_error(STAT_BAD_FMT);
          return;
        end
      end else if (c.command_code == CMD_SET) begin
        if (fmt == FMT_DEFAULT) begin
          fmt = c.color_given ? FMT_RGB : FMT_LEVEL;
        end
        if (fmt == FMT_LEVEL) begin
          frame.push_back(c.level);
        end else if (fmt == FMT_RGB) begin
          frame.push_back(c.red);
          frame.push_back(c.green);
          frame.push_back(c.blue);
          frame.push_back(8'h00);
        end else begin
          push_error(STAT_BAD_FMT);
          return;
        end
      end else begin
        push_error(STAT_UNSUP);
        return;
      end
      frame.push_back(c.address[7:0]);
      frame.push_back(c.address[15:8]);
      frame.push_back(fmt);
      crc = 8'h00;
      foreach (frame[i]) begin
        data = frame[i];
        repeat (8) begin
          mix = crc[0] ^ data[0];
          crc = crc >> 1;
          if (mix) begin
            crc = crc ^ CRC_POLY;
          end
          data = data >> 1;
        end
      end
      frame.push_back(crc);
      foreach (frame[i]) begin
        beat.frame_byte = frame[i];
        beat.last_byte  = (i == frame.size() - 1);
        beat.status     = STAT_OK;
        expected_beats.push_back(beat);
      end
    endfunction

    function void check_byte(logic [7:0] frame_byte, logic last_byte, logic [1:0] status);
      frame_beat_t want;
      if (expected_beats.size() == 0) begin
        flag_failure($sformatf("unexpected frame byte=%02h last=%0b status=%0d",
                               frame_byte, last_byte, status));
        return;
      end
      want = expected_beats.pop_front();
      if ((frame_byte !== want.frame_byte) || (last_byte !== want.last_byte) ||
          (status !== want.status)) begin
        flag_failure($sformatf("expected byte=%02h last=%0b status=%0d, got byte=%02h last=%0b status=%0d",
                               want.frame_byte, want.last_byte, want.status,
                               frame_byte, last_byte, status));
      end
    endfunction

  endclass

endpackage

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the command frame builder. A directed set of commands covers
// every format and error path, then random commands run under three idling
// patterns and one long output stall; every frame byte is checked in order.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import rfcfb_pkg::*;
  import rfcfb_tb_pkg::*;

  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rfcfb_cmd_if   cmd_if ();
  rfcfb_frame_if frame_if ();

  rf_command_frame_builder_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .frame_o (frame_if)
  );

  frame_scoreboard sb = new;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned hold_requests;
  logic [15:0] hot_addr [8];

  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned hold_served;
    int unsigned hold_left;
    hold_served = 0;
    hold_left = 0;
    frame_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && frame_if.valid && frame_if.ready) begin
        sb.check_byte(frame_if.frame_byte, frame_if.last_byte, frame_if.status);
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        frame_if.ready <= 1'b0;
      end else begin
        frame_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_command(input cmd_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.command_code <= c.command_code;
    cmd_if.format_code  <= c.format_code;
    cmd_if.level        <= c.level;
    cmd_if.color_given  <= c.color_given;
    cmd_if.red          <= c.red;
    cmd_if.green        <= c.green;
    cmd_if.blue         <= c.blue;
    cmd_if.toggle_given <= c.toggle_given;
    cmd_if.toggle_value <= c.toggle_value;
    cmd_if.address      <= c.address;
    @(posedge clk_i);
    while (!cmd_if.ready) begin
      @(posedge clk_i);
    end
    sb.note_command(c);
  endtask

  function automatic cmd_t directed_cmd(logic [7:0] cmd, logic [7:0] fmt, logic [7:0] lvl,
                                        logic color, logic [23:0] rgb, logic tgiven,
                                        logic tval, logic [15:0] addr);
    cmd_t c;
    c.command_code = cmd;
    c.format_code  = fmt;
    c.level        = lvl;
    c.color_given  = color;
    {c.red, c.green, c.blue} = rgb;
    c.toggle_given = tgiven;
    c.toggle_value = tval;
    c.address      = addr;
    return c;
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int unsigned kind;
    kind = $urandom_range(99);
    c.level        = 8'($urandom);
    c.red          = 8'($urandom);
    c.green        = 8'($urandom);
    c.blue         = 8'($urandom);
    c.color_given  = 1'($urandom_range(1));
    c.toggle_given = ($urandom_range(99) < 30);
    c.toggle_value = 1'($urandom_range(1));
    c.address      = ($urandom_range(99) < 50) ? hot_addr[$urandom_range(7)] : 16'($urandom);
    if (kind < 45) begin
      case ($urandom_range(7))
        0: c.command_code = CMD_PLAIN_9;
        1: c.command_code = CMD_PLAIN_10;
        2: c.command_code = CMD_PLAIN_15;
        3: c.command_code = CMD_PLAIN_17;
        default: c.command_code = 8'($urandom_range(CMD_PLAIN_LAST));
      endcase
      case ($urandom_range(9))
        0, 1: c.format_code = FMT_NONE;
        2: c.format_code = 8'($urandom_range(254, 1));
        default: c.format_code = FMT_DEFAULT;
      endcase
    end else if (kind < 85) begin
      c.command_code = CMD_SET;
      case ($urandom_range(9))
        0, 1: c.format_code = FMT_LEVEL;
        2, 3: c.format_code = FMT_RGB;
        4: c.format_code = 8'($urandom);
        default: c.format_code = FMT_DEFAULT;
      endcase
    end else begin
      c.command_code = 8'($urandom);
      c.format_code  = $urandom_range(1) ? FMT_DEFAULT : 8'($urandom);
    end
    return c;
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) begin
      send_command(random_command());
    end
  endtask

  initial begin
    cmd_if.valid        = 1'b0;
    cmd_if.command_code = '0;
    cmd_if.format_code  = '0;
    cmd_if.level        = '0;
    cmd_if.color_given  = 1'b0;
    cmd_if.red          = '0;
    cmd_if.green        = '0;
    cmd_if.blue         = '0;
    cmd_if.toggle_given = 1'b0;
    cmd_if.toggle_value = 1'b0;
    cmd_if.address      = '0;
    hold_requests = 0;
    hot_addr[0] = 16'h0000;
    hot_addr[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) begin
      hot_addr[i] = 16'($urandom);
    end

    src_idle_pct = 33;
    snk_idle_pct = 85;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_command(directed_cmd(8'd0, FMT_DEFAULT, 8'h00, 1'b0, 24'h0, 1'b0, 1'b0, 16'h0000));
    send_command(directed_cmd(8'd0, FMT_DEFAULT, 8'h00, 1'b0, 24'h0, 1'b0, 1'b0, 16'h0000));
    send_command(directed_cmd(CMD_PLAIN_LAST, FMT_NONE, 8'hFF, 1'b1, 24'hFFFFFF, 1'b1, 1'b1,
                              16'hFFFF));
    send_command(directed_cmd(CMD_PLAIN_9, FMT_DEFAULT, 8'h00, 1'b0, 24'h0, 1'b0, 1'b0,
                              16'h1234));
    send_command(directed_cmd(CMD_PLAIN_10, FMT_DEFAULT, 8'h00, 1'b0, 24'h0, 1'b0, 1'b0,
                              16'h8001));
    send_command(directed_cmd(CMD_PLAIN_15, FMT_DEFAULT, 8'h00, 1'b0, 24'h0, 1'b1, 1'b0,
                              16'hFFFF));
    send_command(directed_cmd(CMD_PLAIN_17, FMT_DEFAULT, 8'h00, 1'b0, 24'h0, 1'b0, 1'b0,
                              16'hFFFF));
    send_command(directed_cmd(8'd1, FMT_RGB, 8'h00, 1'b0, 24'h0, 1'b0, 1'b0, 16'h0000));
    send_command(directed_cmd(8'd2, FMT_NONE, 8'h00, 1'b0, 24'h0, 1'b0, 1'b0, 16'h0000));
    send_command(directed_cmd(8'd3, 8'hFE, 8'h00, 1'b0, 24'h0, 1'b0, 1'b0, 16'h5A5A));
    send_command(directed_cmd(8'd4, FMT_LEVEL, 8'h00, 1'b0, 24'h0, 1'b1, 1'b1, 16'h5A5A));
    send_command(directed_cmd(CMD_SET, FMT_DEFAULT, 8'h00, 1'b0, 24'hFFFFFF, 1'b0, 1'b0,
                              16'h00FF));
    send_command(directed_cmd(CMD_SET, FMT_DEFAULT, 8'hFF, 1'b0, 24'h0, 1'b0, 1'b0, 16'h00FF));
    send_command(directed_cmd(CMD_SET, FMT_DEFAULT, 8'h00, 1'b1, 24'hFFFFFF, 1'b0, 1'b0,
                              16'hFF00));
    send_command(directed_cmd(CMD_SET, FMT_DEFAULT, 8'hFF, 1'b1, 24'h000000, 1'b1, 1'b1,
                              16'hFF00));
    send_command(directed_cmd(CMD_SET, FMT_LEVEL, 8'hA5, 1'b1, 24'h123456, 1'b0, 1'b0,
                              16'hC3C3));
    send_command(directed_cmd(CMD_SET, FMT_RGB, 8'hA5, 1'b0, 24'h123456, 1'b0, 1'b0,
                              16'hC3C3));
    send_command(directed_cmd(CMD_SET, FMT_NONE, 8'h00, 1'b0, 24'h0, 1'b0, 1'b0, 16'h0001));
    send_command(directed_cmd(CMD_SET, 8'd2, 8'h00, 1'b1, 24'h0, 1'b0, 1'b0, 16'h0001));
    send_command(directed_cmd(CMD_SET + 8'd1, FMT_DEFAULT, 8'h00, 1'b0, 24'h0, 1'b0, 1'b0,
                              16'h0002));
    send_command(directed_cmd(CMD_SET + 8'd2, FMT_NONE, 8'h00, 1'b0, 24'h0, 1'b0, 1'b0,
                              16'h0002));
    send_command(directed_cmd(CMD_PLAIN_15 + 8'd1, FMT_DEFAULT, 8'h00, 1'b0, 24'h0, 1'b0,
                              1'b0, 16'h0003));
    send_command(directed_cmd(CMD_PLAIN_17 + 8'd1, FMT_DEFAULT, 8'h00, 1'b0, 24'h0, 1'b0,
                              1'b0, 16'h0003));
    send_command(directed_cmd(8'hFF, FMT_DEFAULT, 8'hFF, 1'b1, 24'hFFFFFF, 1'b1, 1'b1,
                              16'hFFFF));
    send_command(directed_cmd(CMD_PLAIN_17, FMT_DEFAULT, 8'h00, 1'b0, 24'h0, 1'b0, 1'b0,
                              16'hFFFF));
    run_random(150);

    src_idle_pct = 85;
    snk_idle_pct = 33;
    run_random(150);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_requests = hold_requests + 1;
    run_random(170);

    cmd_if.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.pending() != 0) begin
      $display("ERROR: %0d expected frame bytes never arrived", sb.pending());
    end
    if ((sb.failures == 0) && (sb.pending() == 0)) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rfcfb_pkg.sv
sv/rfcfb_if.sv
sv/rfcfb_toggle_mem.sv
sv/rfcfb_frame_build.sv
sv/rfcfb_serializer.sv
sv/rf_command_frame_builder_core.sv
dv/rfcfb_tb_pkg.sv
dv/tb_top.sv
